// File: src/lpr_pkg.sv
// lpr_pkg: shared types and constants for the lru page replacement block
// no dependencies; imported by every module of the block
`default_nettype none

package lpr_pkg;

  // default geometry, handed down to the top level parameters as their defaults
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // fixed field widths
  localparam int PAGE_IN_W  = 16;
  localparam int CFG_W      = 5;
  localparam int IDX_OUT_W  = 4;
  localparam int FAULT_W    = 32;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lpr_state_t;

  typedef struct packed {
    logic load;    // capture the page of an accepted beat
    logic lookup;  // compare against all frames, pick the slot
    logic update;  // commit the slot, ranks, counter and result
    logic cfg_we;  // new frame count, flush all frames
  } lpr_cmd_t;

endpackage

`default_nettype wire

// File: src/lpr_ctrl.sv
// lpr_ctrl: sequencer for one page reference (lookup, then update)
// depends on lpr_pkg; drives lpr_dp through lpr_cmd_t
`default_nettype none

module lpr_ctrl
  import lpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  output lpr_cmd_t  cmd
);

  lpr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       go;

  // result slot is free, or frees at this edge
  assign go = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (go) state_nxt = in_tvalid ? ST_LOOKUP : ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cfg_ready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cfg_ready = 1'b1;
      end
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_UPDATE: begin
        // next beat enters while this one commits
        in_tready  = go;
        cmd.update = go;
      end
      default: ;
    endcase
    cmd.load   = in_tvalid && in_tready;
    cmd.cfg_we = cfg_valid && cfg_ready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// File: src/lpr_dp.sv
// lpr_dp: frame table, recency ranks, fault counter and result register
// depends on lpr_pkg; commanded by lpr_ctrl
`default_nettype none

module lpr_dp
  import lpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lpr_cmd_t             cmd,
  input  wire logic [PAGE_IN_W-1:0] page_number,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      out_hit,
  output logic [IDX_OUT_W-1:0]      out_frame_index,
  output logic [FAULT_W-1:0]        out_fault_total
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int KEEP_W = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;

  logic [KEEP_W-1:0]  page_r;
  logic [KEEP_W-1:0]  frame_page_r [FRAMES];
  logic [FRAMES-1:0]  valid_r, valid_nxt;
  logic [RANK_W-1:0]  rank_r [FRAMES];
  logic [RANK_W-1:0]  rank_nxt [FRAMES];
  logic [CFG_W-1:0]   count_r;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               hit_r;

  logic               out_hit_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [FAULT_W-1:0] out_fault_r;

  logic [FRAMES-1:0]  in_use;
  logic [RANK_W-1:0]  rank_last;
  logic               hit_found, empty_found;
  logic [IDX_W-1:0]   hit_idx, empty_idx, lru_idx;
  logic [RANK_W-1:0]  rank_sel;

  // frames below the clamped count are in use; rank of the lru frame is count-1
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i] = (i < 32'(count_r)) || (i == 0);
    end
    if (count_r == '0) rank_last = '0;
    else if (32'(count_r) > FRAMES) rank_last = RANK_W'(FRAMES - 1);
    else rank_last = RANK_W'(32'(count_r) - 1);
  end

  // parallel compare, lowest frame wins
  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_idx     = '0;
    empty_idx   = '0;
    lru_idx     = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (in_use[i] && valid_r[i] && frame_page_r[i] == page_r) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (in_use[i] && !valid_r[i]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
      // ranks of a full table are a permutation, so this match is unique
      if (in_use[i] && valid_r[i] && rank_r[i] == rank_last) lru_idx = IDX_W'(i);
    end
    if (hit_found) slot_nxt = hit_idx;
    else if (empty_found) slot_nxt = empty_idx;
    else slot_nxt = lru_idx;
  end

  // promote the chosen slot; on a fault every other valid frame ages, on a hit only those more recent than it
  always_comb begin
    rank_sel = rank_r[slot_r];
    for (int i = 0; i < FRAMES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (IDX_W'(i) == slot_r) begin
        valid_nxt[i] = 1'b1;
        rank_nxt[i]  = '0;
      end else if (valid_r[i] && (!hit_r || rank_r[i] < rank_sel)) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end
    end
    fault_nxt = fault_r;
    if (!hit_r && fault_r != FAULT_MAX) fault_nxt = fault_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= FRAME_COUNT_RST;
      fault_r <= '0;
      valid_r <= '0;
      for (int i = 0; i < FRAMES; i++) rank_r[i] <= '0;
    end else if (cmd.cfg_we) begin
      count_r <= cfg_data;
      valid_r <= '0;
      for (int i = 0; i < FRAMES; i++) rank_r[i] <= '0;
    end else if (cmd.update) begin
      fault_r <= fault_nxt;
      valid_r <= valid_nxt;
      for (int i = 0; i < FRAMES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) page_r <= page_number[KEEP_W-1:0];
    if (cmd.lookup) begin
      slot_r <= slot_nxt;
      hit_r  <= hit_found;
    end
    if (cmd.update) begin
      if (!hit_r) frame_page_r[slot_r] <= page_r;
      out_hit_r   <= hit_r;
      out_idx_r   <= IDX_OUT_W'(slot_r);
      out_fault_r <= fault_nxt;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_frame_index = out_idx_r;
  assign out_fault_total = out_fault_r;

endmodule

`default_nettype wire

// File: src/lru_page_replacement_top.sv
// lru_page_replacement_top: lru page replacement over a parallel-compare frame table
// depends on lpr_pkg, lpr_ctrl, lpr_dp
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tdata[15:0] page_number
//   out_    | out | out_tvalid/out_tready| tuser hit; tdata frame_index, fault_total
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_data frame_count (flushes all frames)
//
// each reference passes through a compare state over every frame in parallel,
// then a commit state that updates ranks, page and fault counter
// back to back, the next reference is accepted while the current one commits
// the result sits in an output register; the commit state stalls while it is full and not taken
// synchronous active-low reset empties all frames, frame count 16, fault total 0
`default_nettype none

module lru_page_replacement_top
  import lpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] page_number
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [3:0] frame_index, [35:4] fault_total
  output logic                        out_tuser,  // [0] hit
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_W-1:0]       cfg_data    // frame_count
);

  lpr_cmd_t             cmd;
  logic                 hit;
  logic [IDX_OUT_W-1:0] frame_index;
  logic [FAULT_W-1:0]   fault_total;

  lpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  lpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .page_number     (in_tdata[PAGE_IN_W-1:0]),
    .cfg_data        (cfg_data),
    .out_hit         (hit),
    .out_frame_index (frame_index),
    .out_fault_total (fault_total)
  );

  assign out_tuser = hit;
  assign out_tdata = {{(OUT_TDATA_W - FAULT_W - IDX_OUT_W){1'b0}}, fault_total, frame_index};

endmodule

`default_nettype wire

// File: src/lpr_checker.sv
// lpr_checker: port-level checks for lru_page_replacement_top, bound to the top
// depends on lpr_pkg
`default_nettype none

module lpr_checker
  import lpr_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser,
  input wire logic                   cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a reference is busy in its compare cycle right after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !cfg_ready)
    else $error("ready during compare cycle");

  // a fault always counts, so a miss never reports a zero total
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[IDX_OUT_W +: FAULT_W] != '0)
    else $error("fault with zero fault total");

endmodule

bind lru_page_replacement_top lpr_checker u_lpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// File: tb/sv/tb_lru_page_replacement_top.sv
// tb_lru_page_replacement_top: self-checking bench for the lru page replacement block
// a directed table, then random working-set traffic under idle/stall phases and several frame
// counts; each beat is checked against the table or an in-bench lru predictor (needs lpr_pkg)
`default_nettype none

module tb_lru_page_replacement_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpr_pkg::*;

  localparam int FRAME_SLOTS  = FRAMES_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4;
  localparam int HOLD_TICKS   = 300;
  localparam int SEGMENTS     = 11;
  localparam int SEG_ITEMS    = 100;
  localparam int NUM_ROWS     = 28;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    logic [FAULT_W-1:0]   fault_total;
  } page_result_t;

  typedef enum logic {ROW_PAGE, ROW_FRAMES} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [PAGE_IN_W-1:0] value;
    logic                 known;
    page_result_t         typed;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  lru_page_replacement_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [PAGE_IN_W-1:0] held_page [FRAME_SLOTS];
  bit                   held_valid [FRAME_SLOTS];
  int unsigned          recency [FRAME_SLOTS];
  logic [FAULT_W-1:0]   faults_seen = '0;
  logic [CFG_W-1:0]     frame_limit = FRAME_COUNT_RST;

  page_result_t pending_results [$];
  int fail_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  function automatic int frames_active();
    if (frame_limit == 0) return 1;
    if (frame_limit > FRAME_SLOTS) return FRAME_SLOTS;
    return int'(frame_limit);
  endfunction

  function automatic void flush_frames();
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      held_page[i] = '0;
      held_valid[i] = 1'b0;
      recency[i] = 0;
    end
  endfunction

  // frame k becomes newest; valid frames younger than limit age by one
  function automatic void make_newest(int k, int n, int unsigned limit);
    for (int i = 0; i < n; i++) begin
      if (i != k && held_valid[i] && recency[i] < limit) recency[i]++;
    end
    recency[k] = 0;
  endfunction

  function automatic page_result_t lru_reference(logic [PAGE_IN_W-1:0] page);
    int n;
    int slot;
    int unsigned oldest;
    bit found;
    bit empty;
    page_result_t r;
    n = frames_active();
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && held_valid[i] && held_page[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      make_newest(slot, n, recency[slot]);
      r.hit = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !held_valid[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (empty) begin
        held_valid[slot] = 1'b1;
        make_newest(slot, n, 255);
      end else begin
        oldest = 0;
        slot = 0;
        for (int i = 0; i < n; i++) begin
          if (recency[i] > oldest) begin
            oldest = recency[i];
            slot = i;
          end
        end
        make_newest(slot, n, 255);
      end
      held_page[slot] = page;
      if (faults_seen != FAULT_MAX) faults_seen++;
      r.hit = 1'b0;
    end
    r.frame_index = slot[IDX_OUT_W-1:0];
    r.fault_total = faults_seen;
    return r;
  endfunction

  // valid is left high after a beat so that back to back beats never toggle it
  task automatic send_page(input logic [PAGE_IN_W-1:0] page, input logic known,
                           input page_result_t typed);
    page_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= page;
    do @(posedge clk); while (!in_tready);
    r = lru_reference(page);
    pending_results.push_back(known ? typed : r);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] count);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_limit = count;
    flush_frames();
  endtask

  plan_row_t plan [NUM_ROWS] = '{
    '{ROW_PAGE,   16'h0000, 1'b1, '{1'b0, 4'd0, 32'd1}},
    '{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b0, 4'd1, 32'd2}},
    '{ROW_PAGE,   16'h0000, 1'b1, '{1'b1, 4'd0, 32'd2}},
    '{ROW_PAGE,   16'h8001, 1'b1, '{1'b0, 4'd2, 32'd3}},
    '{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b1, 4'd1, 32'd3}},
    '{ROW_PAGE,   16'h7FFE, 1'b1, '{1'b0, 4'd3, 32'd4}},
    '{ROW_FRAMES, 16'd1,    1'b0, '0},
    '{ROW_PAGE,   16'h1234, 1'b1, '{1'b0, 4'd0, 32'd5}},
    '{ROW_PAGE,   16'h1234, 1'b1, '{1'b1, 4'd0, 32'd5}},
    '{ROW_PAGE,   16'h4321, 1'b1, '{1'b0, 4'd0, 32'd6}},
    // zero frames acts as one frame
    '{ROW_FRAMES, 16'd0,    1'b0, '0},
    '{ROW_PAGE,   16'h4321, 1'b1, '{1'b0, 4'd0, 32'd7}},
    '{ROW_PAGE,   16'h4321, 1'b1, '{1'b1, 4'd0, 32'd7}},
    '{ROW_FRAMES, 16'd2,    1'b0, '0},
    '{ROW_PAGE,   16'h0010, 1'b1, '{1'b0, 4'd0, 32'd8}},
    '{ROW_PAGE,   16'h0020, 1'b1, '{1'b0, 4'd1, 32'd9}},
    '{ROW_PAGE,   16'h0010, 1'b1, '{1'b1, 4'd0, 32'd9}},
    '{ROW_PAGE,   16'h0030, 1'b1, '{1'b0, 4'd1, 32'd10}},
    '{ROW_PAGE,   16'h0020, 1'b1, '{1'b0, 4'd0, 32'd11}},
    // counts above the frame total clamp to it
    '{ROW_FRAMES, 16'd17,   1'b0, '0},
    '{ROW_PAGE,   16'hAAAA, 1'b1, '{1'b0, 4'd0, 32'd12}},
    '{ROW_PAGE,   16'h5555, 1'b1, '{1'b0, 4'd1, 32'd13}},
    '{ROW_FRAMES, 16'd31,   1'b0, '0},
    '{ROW_PAGE,   16'h5555, 1'b1, '{1'b0, 4'd0, 32'd14}},
    '{ROW_PAGE,   16'hAAAA, 1'b1, '{1'b0, 4'd1, 32'd15}},
    '{ROW_PAGE,   16'h5555, 1'b1, '{1'b1, 4'd0, 32'd15}},
    '{ROW_PAGE,   16'h0001, 1'b0, '0},
    '{ROW_PAGE,   16'hAAAA, 1'b0, '0}
  };

  // result side: stall pattern, long hold-off on request, beat checking
  initial begin
    page_result_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no reference pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_tuser);
            fail_count++;
          end
          if (out_tdata[3:0] !== want.frame_index) begin
            $error("frame_index: expected %0d, got %0d", want.frame_index, out_tdata[3:0]);
            fail_count++;
          end
          if (out_tdata[35:4] !== want.fault_total) begin
            $error("fault_total: expected %0d, got %0d", want.fault_total, out_tdata[35:4]);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_TICKS;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [PAGE_IN_W-1:0] working_set [20];
    logic [PAGE_IN_W-1:0] page;
    logic [PAGE_IN_W-1:0] last_page;
    logic [CFG_W-1:0] count;
    int set_size;
    int roll;
    flush_frames();
    last_page = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_FRAMES) set_frames(plan[r].value[CFG_W-1:0]);
      else send_page(plan[r].value, plan[r].known, plan[r].typed);
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      case (s)
        0: count = 5'd16;
        1: count = 5'd1;
        2: count = 5'd31;
        3: count = 5'd0;
        4: count = 5'd17;
        5: count = 5'd4;
        default: count = CFG_W'($urandom_range(0, 31));
      endcase
      set_frames(count);
      // working set near the frame count so hits, fills and evictions all occur
      set_size = $urandom_range(1, frames_active() + 3);
      for (int i = 0; i < 20; i++) working_set[i] = PAGE_IN_W'($urandom_range(0, 65535));
      // block fills up and stalls its input while results are held off
      if (s == 4) hold_req = 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if (s == 5 && k == SEG_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        if (k % 25 == 24)
          working_set[$urandom_range(0, set_size - 1)] = PAGE_IN_W'($urandom_range(0, 65535));
        roll = $urandom_range(99);
        if (roll < 15) page = PAGE_IN_W'($urandom_range(0, 65535));
        else if (roll < 30) page = last_page;
        else page = working_set[$urandom_range(0, set_size - 1)];
        last_page = page;
        send_page(page, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: lru_page_replacement_top.f
src/lpr_pkg.sv
src/lpr_ctrl.sv
src/lpr_dp.sv
src/lru_page_replacement_top.sv
src/lpr_checker.sv
tb/sv/tb_lru_page_replacement_top.sv
